// ===== src/lcdm_pkg.sv =====
// Shared types, codes and character tables for the LCD meter display streamer.
// Used by lcdm_digits, lcdm_byte_gen and lcd_meter_display_streamer; no dependencies.
package lcdm_pkg;

    // Request payload: operation select and measured value.
    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] value;
    } in_t;

    // Result payload: one shift register byte and the end-of-stream mark.
    typedef struct packed {
        logic [7:0] spi_byte;
        logic       last;
    } out_t;

    // Operation codes.
    localparam logic [1:0] FUNC_INIT = 2'd0;
    localparam logic [1:0] FUNC_RES  = 2'd1;
    localparam logic [1:0] FUNC_FREQ = 2'd2;

    // Shift register bits.
    localparam logic [7:0] EN_BIT = 8'h80;
    localparam logic [7:0] RS_BIT = 8'h40;

    // Display limits.
    localparam logic [31:0] MAX_RES  = 32'd9999;
    localparam logic [31:0] MAX_FREQ = 32'd99999;

    // Decimal conversion: a value up to 99999 fits in 17 bits and splits into at most five digits.
    localparam int          VAL_W    = 17;
    localparam int          DIGITS   = 5;
    localparam int          DIG_IDX_W = 3;
    // Reciprocal of ten scaled by 2**19; exact for every value below 2**17.
    localparam logic [15:0] RECIP10  = 16'd52429;
    localparam int          RECIP_SH = 19;

    // Nibble counts per stream (index of the final nibble).
    localparam logic [4:0] INIT_LAST_NIB = 5'd10;
    localparam logic [4:0] LINE_LAST_NIB = 5'd17;

    // Set-address commands for the two display lines.
    localparam logic [7:0] ADDR_LINE0 = 8'h80;
    localparam logic [7:0] ADDR_LINE1 = 8'hC0;

    // Nibble sent alone at the start of the init sequence.
    localparam logic [3:0] INIT_NIBBLE = 4'h2;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    // Init command list after the first lone nibble.
    function automatic logic [7:0] init_cmd(input logic [2:0] idx);
        logic [7:0] cmd;
        case (idx)
            3'd0:    cmd = 8'h28;
            3'd1:    cmd = 8'h0C;
            3'd2:    cmd = 8'h06;
            3'd3:    cmd = 8'h01;
            3'd4:    cmd = 8'h80;
            default: cmd = 8'h00;
        endcase
        return cmd;
    endfunction

    // Overload text: "** OL **" for resistance, "** OL  *" for frequency.
    function automatic logic [7:0] ol_char(input logic [1:0] func, input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h2A;
            3'd1:    ch = 8'h2A;
            3'd2:    ch = CHAR_SPACE;
            3'd3:    ch = 8'h4F;
            3'd4:    ch = 8'h4C;
            3'd5:    ch = CHAR_SPACE;
            3'd6:    ch = (func == FUNC_FREQ) ? CHAR_SPACE : 8'h2A;
            default: ch = 8'h2A;
        endcase
        return ch;
    endfunction

    // Unit suffix: " Ohm" for resistance, " Hz " for frequency.
    function automatic logic [7:0] suffix_char(input logic [1:0] func, input logic [1:0] pos);
        logic [7:0] ch;
        case (pos)
            2'd0:    ch = CHAR_SPACE;
            2'd1:    ch = (func == FUNC_FREQ) ? 8'h48 : 8'h4F;
            2'd2:    ch = (func == FUNC_FREQ) ? 8'h7A : 8'h68;
            default: ch = (func == FUNC_FREQ) ? CHAR_SPACE : 8'h6D;
        endcase
        return ch;
    endfunction

    // Position of the stream, handed from the sequencer to the byte generator.
    typedef struct packed {
        logic [1:0] func;
        logic       ol;
        logic [4:0] nib;
        logic [1:0] phase;
    } pos_t;

endpackage

// ===== src/lcdm_digits.sv =====
// Decimal digit extraction, one digit per cycle, least significant first.
// Depends on lcdm_pkg for widths and the reciprocal constant.
module lcdm_digits (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      load,
    input  logic [lcdm_pkg::VAL_W-1:0]                load_value,
    output logic [lcdm_pkg::DIGITS-1:0][3:0]          digits,
    output logic [lcdm_pkg::DIG_IDX_W-1:0]            ndig
);

    localparam int PROD_W = lcdm_pkg::VAL_W + 16;

    logic [lcdm_pkg::VAL_W-1:0]           work_reg;
    logic [lcdm_pkg::DIG_IDX_W-1:0]       step_reg;
    logic [lcdm_pkg::DIGITS-1:0][3:0]     dig_reg;
    logic [lcdm_pkg::DIG_IDX_W-1:0]       ndig_reg;

    logic [PROD_W-1:0]                    prod;
    logic [lcdm_pkg::VAL_W-1:0]           quot;
    logic [lcdm_pkg::VAL_W-1:0]           times10;
    logic [3:0]                           rem;

    // Divide by ten with a reciprocal multiply, then take the remainder.
    always_comb
    begin
        prod    = PROD_W'(work_reg) * PROD_W'(lcdm_pkg::RECIP10);
        quot    = lcdm_pkg::VAL_W'(prod >> lcdm_pkg::RECIP_SH);
        times10 = (quot << 3) + (quot << 1);
        rem     = 4'(work_reg - times10);
    end

    // Step control: load restarts, then five steps run to completion.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= lcdm_pkg::DIG_IDX_W'(lcdm_pkg::DIGITS);
            ndig_reg <= lcdm_pkg::DIG_IDX_W'(1);
        end
        else if (load)
        begin
            step_reg <= '0;
            ndig_reg <= lcdm_pkg::DIG_IDX_W'(1);
        end
        else if (step_reg < lcdm_pkg::DIG_IDX_W'(lcdm_pkg::DIGITS))
        begin
            step_reg <= step_reg + 1'b1;
            // The highest nonzero digit sets the printed width.
            if (rem != 4'd0)
            begin
                ndig_reg <= step_reg + 1'b1;
            end
        end
    end

    // Working value and digit store.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            work_reg <= load_value;
        end
        else if (step_reg < lcdm_pkg::DIG_IDX_W'(lcdm_pkg::DIGITS))
        begin
            work_reg          <= quot;
            dig_reg[step_reg] <= rem;
        end
    end

    assign digits = dig_reg;
    assign ndig   = ndig_reg;

endmodule

// ===== src/lcdm_byte_gen.sv =====
// Builds the shift register byte for one stream position from the digits.
// Depends on lcdm_pkg for the position struct, codes and character tables.
module lcdm_byte_gen (
    input  lcdm_pkg::pos_t                            pos,
    input  logic [lcdm_pkg::DIGITS-1:0][3:0]          digits,
    input  logic [lcdm_pkg::DIG_IDX_W-1:0]            ndig,
    output lcdm_pkg::out_t                            byte_out
);

    logic [2:0] cmd_idx;
    logic [7:0] cmd;
    logic [2:0] ch_pos;
    logic [1:0] lead_idx;
    logic [2:0] wide_idx;
    logic [7:0] ch;
    logic [7:0] lcd_byte;
    logic [3:0] nibble;
    logic       rs;
    logic       en;
    logic [4:0] last_nib;

    // Init command and character position from the nibble count.
    always_comb
    begin
        cmd_idx  = 3'((pos.nib - 5'd1) >> 1);
        cmd      = lcdm_pkg::init_cmd(cmd_idx);
        ch_pos   = 3'(pos.nib[4:1] - 4'd1);
        lead_idx = 2'(3'd3 - ch_pos);
        wide_idx = 3'(3'd4 - ch_pos);
    end

    // Character text: overload message, or number then unit suffix.
    always_comb
    begin
        if (pos.ol)
        begin
            ch = lcdm_pkg::ol_char(pos.func, ch_pos);
        end
        else if (ndig == lcdm_pkg::DIG_IDX_W'(lcdm_pkg::DIGITS))
        begin
            // Five digits fill the field; the suffix loses its last character.
            if (ch_pos < 3'd5)
            begin
                ch = lcdm_pkg::CHAR_ZERO | {4'h0, digits[wide_idx]};
            end
            else
            begin
                ch = lcdm_pkg::suffix_char(pos.func, 2'(ch_pos - 3'd5));
            end
        end
        else if (ch_pos < 3'd4)
        begin
            // Right-justified in four places with leading blanks.
            if (lcdm_pkg::DIG_IDX_W'(lead_idx) < ndig)
            begin
                ch = lcdm_pkg::CHAR_ZERO | {4'h0, digits[lead_idx]};
            end
            else
            begin
                ch = lcdm_pkg::CHAR_SPACE;
            end
        end
        else
        begin
            ch = lcdm_pkg::suffix_char(pos.func, ch_pos[1:0]);
        end
    end

    // Select the nibble and the RS bit for this position.
    always_comb
    begin
        lcd_byte = 8'h00;
        nibble   = 4'h0;
        rs       = 1'b0;
        if (pos.func == lcdm_pkg::FUNC_INIT)
        begin
            last_nib = lcdm_pkg::INIT_LAST_NIB;
            if (pos.nib == 5'd0)
            begin
                nibble = lcdm_pkg::INIT_NIBBLE;
            end
            else
            begin
                lcd_byte = cmd;
                nibble   = pos.nib[0] ? lcd_byte[7:4] : lcd_byte[3:0];
            end
        end
        else
        begin
            last_nib = lcdm_pkg::LINE_LAST_NIB;
            if (pos.nib < 5'd2)
            begin
                lcd_byte = (pos.func == lcdm_pkg::FUNC_FREQ) ? lcdm_pkg::ADDR_LINE1
                                                             : lcdm_pkg::ADDR_LINE0;
            end
            else
            begin
                lcd_byte = ch;
                rs       = 1'b1;
            end
            nibble = pos.nib[0] ? lcd_byte[3:0] : lcd_byte[7:4];
        end
    end

    // Each nibble is sent with EN low, high, then low.
    always_comb
    begin
        en                = (pos.phase == 2'd1);
        byte_out.spi_byte = (en ? lcdm_pkg::EN_BIT : 8'h00)
                          | (rs ? lcdm_pkg::RS_BIT : 8'h00)
                          | {4'h0, nibble};
        byte_out.last     = (pos.phase == 2'd2) && (pos.nib == last_nib);
    end

endmodule

// ===== src/lcd_meter_display_streamer.sv =====
// Top level of the LCD meter display streamer: request register, byte sequencer
// and result register. Depends on lcdm_pkg, lcdm_digits and lcdm_byte_gen.
//
// A request (start high while busy is low) produces the full shift register byte
// stream for one LCD operation, one byte per clock on result with strobe high:
// 33 bytes for init and 54 bytes for a resistance or frequency write. The next
// request is taken in the cycle the final byte is formed, and streams follow each
// other without a gap. The first byte is on the result ports from the clock edge
// after the one that accepts the request.
// The receiver cannot stall: each byte is shown for exactly one cycle, and
// result.last marks the final byte. An unused func code is accepted and produces
// no bytes.
module lcd_meter_display_streamer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  lcdm_pkg::in_t   req,
    output logic            busy,
    output logic            strobe,
    output lcdm_pkg::out_t  result
);

    logic                                   accept;
    logic                                   active_reg;
    logic [1:0]                             func_reg;
    logic                                   ol_reg;
    logic [4:0]                             nib_reg;
    logic [1:0]                             phase_reg;
    logic                                   strobe_reg;
    lcdm_pkg::out_t                         result_reg;
    logic                                   ol_next;
    lcdm_pkg::pos_t                         pos;
    lcdm_pkg::out_t                         gen_byte;
    logic [lcdm_pkg::DIGITS-1:0][3:0]       digits;
    logic [lcdm_pkg::DIG_IDX_W-1:0]         ndig;

    assign accept = start && !busy;
    assign busy   = active_reg && !gen_byte.last;

    // Values the display cannot show are replaced by the overload text.
    always_comb
    begin
        if (req.func == lcdm_pkg::FUNC_FREQ)
        begin
            ol_next = (req.value == 32'd0) || (req.value > lcdm_pkg::MAX_FREQ);
        end
        else
        begin
            ol_next = (req.value > lcdm_pkg::MAX_RES);
        end
    end

    // Decimal digits of the value, ready before the first character is sent.
    lcdm_digits u_digits (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .load_value (req.value[lcdm_pkg::VAL_W-1:0]),
        .digits     (digits),
        .ndig       (ndig)
    );

    // Current stream position.
    always_comb
    begin
        pos.func  = func_reg;
        pos.ol    = ol_reg;
        pos.nib   = nib_reg;
        pos.phase = phase_reg;
    end

    lcdm_byte_gen u_byte_gen (
        .pos      (pos),
        .digits   (digits),
        .ndig     (ndig),
        .byte_out (gen_byte)
    );

    // Byte sequencer: three phases per nibble, nibbles until the last byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            func_reg   <= lcdm_pkg::FUNC_INIT;
            ol_reg     <= 1'b0;
            nib_reg    <= '0;
            phase_reg  <= '0;
        end
        else if (accept)
        begin
            active_reg <= (req.func == lcdm_pkg::FUNC_INIT)
                       || (req.func == lcdm_pkg::FUNC_RES)
                       || (req.func == lcdm_pkg::FUNC_FREQ);
            func_reg   <= req.func;
            ol_reg     <= ol_next;
            nib_reg    <= '0;
            phase_reg  <= '0;
        end
        else if (active_reg)
        begin
            if (gen_byte.last)
            begin
                active_reg <= 1'b0;
            end
            else if (phase_reg == 2'd2)
            begin
                phase_reg <= '0;
                nib_reg   <= nib_reg + 1'b1;
            end
            else
            begin
                phase_reg <= phase_reg + 1'b1;
            end
        end
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= active_reg;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        result_reg <= gen_byte;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule
